FILE: rtl/primitive_assembler_unit_macros.svh
// ----------------------------------------------------------------------------
// primitive_assembler_unit assertion macros
// Shared property forms for the primitive assembler checks.
// ----------------------------------------------------------------------------
`ifndef PRIMITIVE_ASSEMBLER_UNIT_MACROS_SVH
`define PRIMITIVE_ASSEMBLER_UNIT_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while in reset
`define PAU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("primitive_assembler_unit: check failed");

// Next-cycle implication, clocked on i_clk, off while in reset
`define PAU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("primitive_assembler_unit: check failed");

`endif

FILE: rtl/pau_pkg.sv
// ----------------------------------------------------------------------------
// pau_pkg
// Types and constants shared by the primitive assembler modules.
// ----------------------------------------------------------------------------
package pau_pkg;

    // Field and port widths
    localparam int FIELD_W          = 32;
    localparam int CFG_DATA_W       = 32;
    localparam int INDEX_WIDTH_DEF  = 32;
    localparam int QUEUE_DEPTH_DEF  = 4;
    localparam logic [31:0] RESTART_DEFAULT = 32'd65535;

    // Assembly modes; code 3 is treated as a list
    typedef enum logic [1:0] {
        MODE_LIST  = 2'd0,
        MODE_STRIP = 2'd1,
        MODE_FAN   = 2'd2
    } t_mode;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_MODE    = 1'b0,
        CFG_RESTART = 1'b1
    } t_cfg_index;

    // Input item
    typedef struct packed {
        logic [FIELD_W-1:0] vertex_index;
        logic               end_of_batch;
    } t_in_item;

    // Output item: one triangle
    typedef struct packed {
        logic [FIELD_W-1:0] corner_first;
        logic [FIELD_W-1:0] corner_second;
        logic [FIELD_W-1:0] corner_third;
    } t_out_item;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Front status for checks
    typedef struct packed {
        logic       accept;
        logic [1:0] held_count;
    } t_front_status;

endpackage

FILE: rtl/pau_front.sv
// ----------------------------------------------------------------------------
// pau_front
// Accepts index items, holds the assembly state and the configuration
// registers, and pushes each completed triangle into the queue.
// ----------------------------------------------------------------------------
module pau_front #(
    parameter int INDEX_WIDTH = pau_pkg::INDEX_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  pau_pkg::t_cfg_index           i_cfg_index,
    input  logic [pau_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    input  pau_pkg::t_in_item             i_in_item,
    output logic                          o_in_stall,
    input  pau_pkg::t_q_status            i_q_status,
    output logic                          o_push,
    output logic [3*INDEX_WIDTH-1:0]      o_tri,
    output pau_pkg::t_front_status        o_status
);
    import pau_pkg::*;

    t_mode                  r_mode;
    logic [INDEX_WIDTH-1:0] r_restart;
    logic [INDEX_WIDTH-1:0] r_older, n_older;
    logic [INDEX_WIDTH-1:0] r_newer, n_newer;
    logic [INDEX_WIDTH-1:0] r_center, n_center;
    logic [1:0]             r_held, n_held;

    logic                   w_accept;
    logic                   w_restart;
    logic [INDEX_WIDTH-1:0] w_idx;

    assign o_in_stall = i_q_status.full;
    assign w_accept   = i_in_valid && !i_q_status.full;
    assign w_idx      = i_in_item.vertex_index[INDEX_WIDTH-1:0];
    assign w_restart  = (w_idx == r_restart);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_STRIP;
            r_restart <= RESTART_DEFAULT[INDEX_WIDTH-1:0];
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MODE:    r_mode    <= t_mode'(i_cfg_data[1:0]);
                CFG_RESTART: r_restart <= i_cfg_data[INDEX_WIDTH-1:0];
                default:     ;
            endcase
        end
    end

    // Assembly rules per mode
    always_comb begin
        n_older  = r_older;
        n_newer  = r_newer;
        n_center = r_center;
        n_held   = r_held;
        o_push   = 1'b0;
        o_tri    = {r_older, r_newer, w_idx};
        if (w_accept) begin
            if (w_restart) begin
                n_older  = '0;
                n_newer  = '0;
                n_center = '0;
                n_held   = '0;
            end else begin
                unique case (r_mode)
                    MODE_STRIP: begin
                        if (r_held == 2'd0) begin
                            n_older = w_idx;
                            n_held  = 2'd1;
                        end else if (r_held == 2'd1) begin
                            n_newer = w_idx;
                            n_held  = 2'd2;
                        end else begin
                            o_push  = 1'b1;
                            n_older = r_newer;
                            n_newer = w_idx;
                            n_held  = 2'd2;
                        end
                    end
                    MODE_FAN: begin
                        o_tri = {r_center, r_newer, w_idx};
                        if (r_held == 2'd0) begin
                            n_center = w_idx;
                            n_held   = 2'd1;
                        end else if (r_held == 2'd1) begin
                            n_newer = w_idx;
                            n_held  = 2'd2;
                        end else begin
                            o_push  = 1'b1;
                            n_newer = w_idx;
                            n_held  = 2'd2;
                        end
                    end
                    default: begin
                        // list, also the unused code
                        if (r_held == 2'd0) begin
                            n_older = w_idx;
                            n_held  = 2'd1;
                        end else if (r_held == 2'd1) begin
                            n_newer = w_idx;
                            n_held  = 2'd2;
                        end else begin
                            o_push = 1'b1;
                            n_held = 2'd0;
                        end
                    end
                endcase
            end
            // end of batch clears after the item
            if (i_in_item.end_of_batch) begin
                n_older  = '0;
                n_newer  = '0;
                n_center = '0;
                n_held   = '0;
            end
        end
    end

    // Assembly state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older  <= '0;
            r_newer  <= '0;
            r_center <= '0;
            r_held   <= '0;
        end else begin
            r_older  <= n_older;
            r_newer  <= n_newer;
            r_center <= n_center;
            r_held   <= n_held;
        end
    end

    assign o_status.accept     = w_accept;
    assign o_status.held_count = r_held;

endmodule

FILE: rtl/pau_queue.sv
// ----------------------------------------------------------------------------
// pau_queue
// Short triangle queue between the front and the back.
// ----------------------------------------------------------------------------
module pau_queue #(
    parameter int WIDTH = 96,
    parameter int DEPTH = pau_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [WIDTH-1:0]   i_data,
    input  logic               i_pop,
    output logic [WIDTH-1:0]   o_data,
    output pau_pkg::t_q_status o_status
);
    import pau_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;

    // Pointer and count update
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Slot storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

    assign o_data         = r_slot[r_rptr];
    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

FILE: rtl/pau_back.sv
// ----------------------------------------------------------------------------
// pau_back
// Output stage: pulls triangles from the queue into the output register.
// ----------------------------------------------------------------------------
module pau_back #(
    parameter int INDEX_WIDTH = pau_pkg::INDEX_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  pau_pkg::t_q_status       i_q_status,
    input  logic [3*INDEX_WIDTH-1:0] i_q_data,
    output logic                     o_pop,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output pau_pkg::t_out_item       o_out_item
);
    import pau_pkg::*;

    logic                     r_valid;
    logic [3*INDEX_WIDTH-1:0] r_tri;

    // Load when the register is free or being taken
    assign o_pop = !i_q_status.empty && (!r_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_tri <= i_q_data;
        end
    end

    assign o_out_valid              = r_valid;
    assign o_out_item.corner_first  = FIELD_W'(r_tri[3*INDEX_WIDTH-1:2*INDEX_WIDTH]);
    assign o_out_item.corner_second = FIELD_W'(r_tri[2*INDEX_WIDTH-1:INDEX_WIDTH]);
    assign o_out_item.corner_third  = FIELD_W'(r_tri[INDEX_WIDTH-1:0]);

endmodule

FILE: rtl/primitive_assembler_unit.sv
// ----------------------------------------------------------------------------
// primitive_assembler_unit
// Builds triangles from a vertex index stream in list, strip or fan mode.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) takes one vertex
//   index and an end-of-batch flag per item. Output channel (o_out_valid /
//   i_out_stall / o_out_item) delivers one triangle of three indices.
//   Config port: i_cfg_we with i_cfg_index selects mode (list, strip, fan)
//   or the restart index; write only while the block is idle.
//   Throughput: one index per cycle while o_in_stall is low. The front updates
//   the assembly state in the accept cycle and pushes a triangle into a small
//   queue; the back then loads it from the queue into the output register,
//   which drives o_out_valid.
//   A restart index emits nothing and clears assembly; end of batch clears
//   after its item. Partial triangles are dropped.
//   Stall: the queue holds QUEUE_DEPTH triangles and the output register
//   one more while the output stalls; o_in_stall rises when the queue is full.
//   Reset (synchronous, active low): mode strip, restart 65535, assembly
//   state cleared, queue and output register empty.
// ----------------------------------------------------------------------------
`include "primitive_assembler_unit_macros.svh"

module primitive_assembler_unit #(
    parameter int INDEX_WIDTH = pau_pkg::INDEX_WIDTH_DEF,
    parameter int QUEUE_DEPTH = pau_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  pau_pkg::t_cfg_index            i_cfg_index,
    input  logic [pau_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  pau_pkg::t_in_item              i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output pau_pkg::t_out_item             o_out_item
);
    import pau_pkg::*;

    logic                     w_push;
    logic                     w_pop;
    logic [3*INDEX_WIDTH-1:0] w_push_tri;
    logic [3*INDEX_WIDTH-1:0] w_q_data;
    t_q_status                w_q_status;
    t_front_status            w_front_status;

    // Front: accept and assemble
    pau_front #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .i_q_status  (w_q_status),
        .o_push      (w_push),
        .o_tri       (w_push_tri),
        .o_status    (w_front_status)
    );

    // Triangle queue
    pau_queue #(
        .WIDTH (3 * INDEX_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_push_tri),
        .i_pop    (w_pop),
        .o_data   (w_q_data),
        .o_status (w_q_status)
    );

    // Back: output register
    pau_back #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (w_q_status),
        .i_q_data    (w_q_data),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // Checks
    `PAU_ASSERT_IMP(a_no_overflow, w_push, !w_q_status.full)
    `PAU_ASSERT_IMP(a_no_underflow, w_pop, !w_q_status.empty)
    `PAU_ASSERT_NXT(a_eob_clears, w_front_status.accept && i_in_item.end_of_batch,
                    w_front_status.held_count == 2'd0)

endmodule
